// ===== rtl/hamming_8_4_trellis_soft_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Hamming (8,4) trellis soft decoder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HAMMING_8_4_TRELLIS_SOFT_DECODER_ASSERT_SVH
`define HAMMING_8_4_TRELLIS_SOFT_DECODER_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next cycle
`define HMD84_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition holds at every clock edge outside reset
`define HMD84_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ===== rtl/hmd84_pkg.sv =====
// ----------------------------------------------------------------------------
// hmd84_pkg
// Shared constants and types of the Hamming (8,4) trellis soft decoder.
// ----------------------------------------------------------------------------
package hmd84_pkg;

  // Default soft sample width
  localparam int unsigned SampleBitsDef = 8;
  // Codeword length and message length
  localparam int unsigned NumSamples    = 8;
  localparam int unsigned MsgBits       = 4;
  // Branches per trellis section
  localparam int unsigned NumBranches   = 4;
  localparam int unsigned LeftBits      = 3;

  // Survivor labels of the four branches from both half-trellises
  typedef struct packed {
    logic [NumBranches-1:0][LeftBits-1:0] left;   // message bits 0..2
    logic [NumBranches-1:0]               right;  // message bit 3
  } hmd84_code_t;

endpackage

// ===== rtl/hamming_8_4_trellis_soft_decoder.sv =====
// ----------------------------------------------------------------------------
// hamming_8_4_trellis_soft_decoder
// Soft-decision decoder for the extended Hamming (8,4,4) code.
// ----------------------------------------------------------------------------
// One codeword of eight signed soft samples is taken whenever start_i is high;
// busy_o stays low, so a codeword may be presented in every cycle and the
// decoder sustains one transaction per clock. The samples land in an input
// register, one pass of saturating adders and comparators (pair and quad
// sums, half-trellis survivors, branch totals, minimum tree) feeds the result
// register, and valid_o strobes decoded_message_o for exactly one cycle,
// rising at the clock edge after the accepting edge. The result cannot be
// held off: a receiver must take it in the cycle that valid_o marks.
// Results come out in order.
// ----------------------------------------------------------------------------
`include "hamming_8_4_trellis_soft_decoder_assert.svh"

module hamming_8_4_trellis_soft_decoder import hmd84_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_3_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_4_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_5_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_6_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_7_i,
  output logic                          valid_o,
  output logic [MsgBits-1:0]            decoded_message_o
);

  logic                                          accept;
  logic                                          in_vld_q;
  logic signed [NumSamples-1:0][SAMPLE_BITS-1:0] sample_d, sample_q;
  logic signed [NumBranches-1:0][SAMPLE_BITS-1:0] left_metric, right_metric;
  hmd84_code_t                                   code;
  logic [MsgBits-1:0]                            message;
  logic                                          valid_q;
  logic [MsgBits-1:0]                            msg_q;

  // Never stalls: a transaction is taken on every start
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign sample_d = {sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                     sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // Input sample register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_d;
    end
  end

  // Branch metrics and half-trellis survivors
  hmd84_branch #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_branch (
    .sample_i       (sample_q),
    .left_metric_o  (left_metric),
    .right_metric_o (right_metric),
    .code_o         (code)
  );

  // Branch totals and final choice
  hmd84_select #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_select (
    .left_metric_i  (left_metric),
    .right_metric_i (right_metric),
    .code_i         (code),
    .message_o      (message)
  );

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_vld_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      msg_q <= message;
    end
  end

  assign valid_o           = valid_q;
  assign decoded_message_o = msg_q;

  // Pipeline checks
  `HMD84_ASSERT_NEXT(a_accept_loads, accept, in_vld_q, "accepted codeword not registered")
  `HMD84_ASSERT_NEXT(a_result_follows, in_vld_q, valid_o, "registered codeword gave no result")
  `HMD84_ASSERT_NEXT(a_no_spurious, !in_vld_q, !valid_o, "result strobe without a codeword")
  `HMD84_ASSERT_ALWAYS(a_never_busy, !busy_o, "decoder refused a transaction")

endmodule

// ===== rtl/hmd84_branch.sv =====
// ----------------------------------------------------------------------------
// hmd84_branch
// Pair and quad sums of the samples and survivor choice in each half-trellis.
// ----------------------------------------------------------------------------
module hmd84_branch import hmd84_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic signed [NumSamples-1:0][SAMPLE_BITS-1:0]  sample_i,
  output logic signed [NumBranches-1:0][SAMPLE_BITS-1:0] left_metric_o,
  output logic signed [NumBranches-1:0][SAMPLE_BITS-1:0] right_metric_o,
  output hmd84_code_t                                     code_o
);

  localparam logic signed [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] Zero   = '0;

  // Saturating add in the sample format
  function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [SAMPLE_BITS:0] s;
    s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
    if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
      sat_add = s[SAMPLE_BITS] ? SatMin : SatMax;
    end else begin
      sat_add = s[SAMPLE_BITS-1:0];
    end
  endfunction

  logic signed [SAMPLE_BITS-1:0] p01, p24, p67, p35, p12, p04;
  logic signed [SAMPLE_BITS-1:0] p37, p56, p14, p02, p57, p36;
  logic signed [SAMPLE_BITS-1:0] q0124, q3567;

  // Pair sums
  always_comb begin
    p01 = sat_add(sample_i[0], sample_i[1]);
    p24 = sat_add(sample_i[2], sample_i[4]);
    p67 = sat_add(sample_i[6], sample_i[7]);
    p35 = sat_add(sample_i[3], sample_i[5]);
    p12 = sat_add(sample_i[1], sample_i[2]);
    p04 = sat_add(sample_i[0], sample_i[4]);
    p37 = sat_add(sample_i[3], sample_i[7]);
    p56 = sat_add(sample_i[5], sample_i[6]);
    p14 = sat_add(sample_i[1], sample_i[4]);
    p02 = sat_add(sample_i[0], sample_i[2]);
    p57 = sat_add(sample_i[5], sample_i[7]);
    p36 = sat_add(sample_i[3], sample_i[6]);
  end

  // Quad sums for the all-zero branch
  assign q0124 = sat_add(p01, p24);
  assign q3567 = sat_add(p35, p67);

  // Left half-trellis: strict less-than, ties go to the second candidate
  always_comb begin
    if (q0124 < Zero) begin
      left_metric_o[0] = q0124; code_o.left[0] = 3'd0;
    end else begin
      left_metric_o[0] = Zero;  code_o.left[0] = 3'd7;
    end
    if (p01 < p24) begin
      left_metric_o[1] = p01; code_o.left[1] = 3'd4;
    end else begin
      left_metric_o[1] = p24; code_o.left[1] = 3'd3;
    end
    if (p12 < p04) begin
      left_metric_o[2] = p12; code_o.left[2] = 3'd1;
    end else begin
      left_metric_o[2] = p04; code_o.left[2] = 3'd6;
    end
    if (p14 < p02) begin
      left_metric_o[3] = p14; code_o.left[3] = 3'd5;
    end else begin
      left_metric_o[3] = p02; code_o.left[3] = 3'd2;
    end
  end

  // Right half-trellis
  always_comb begin
    if (q3567 < Zero) begin
      right_metric_o[0] = q3567; code_o.right[0] = 1'b0;
    end else begin
      right_metric_o[0] = Zero;  code_o.right[0] = 1'b1;
    end
    if (p67 < p35) begin
      right_metric_o[1] = p67; code_o.right[1] = 1'b1;
    end else begin
      right_metric_o[1] = p35; code_o.right[1] = 1'b0;
    end
    if (p37 < p56) begin
      right_metric_o[2] = p37; code_o.right[2] = 1'b0;
    end else begin
      right_metric_o[2] = p56; code_o.right[2] = 1'b1;
    end
    if (p57 < p36) begin
      right_metric_o[3] = p57; code_o.right[3] = 1'b1;
    end else begin
      right_metric_o[3] = p36; code_o.right[3] = 1'b0;
    end
  end

endmodule

// ===== rtl/hmd84_select.sv =====
// ----------------------------------------------------------------------------
// hmd84_select
// Branch totals and the minimum tree that picks the surviving message.
// ----------------------------------------------------------------------------
module hmd84_select import hmd84_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic signed [NumBranches-1:0][SAMPLE_BITS-1:0] left_metric_i,
  input  logic signed [NumBranches-1:0][SAMPLE_BITS-1:0] right_metric_i,
  input  hmd84_code_t                                     code_i,
  output logic [MsgBits-1:0]                              message_o
);

  localparam logic signed [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Saturating add in the sample format
  function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [SAMPLE_BITS:0] s;
    s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
    if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
      sat_add = s[SAMPLE_BITS] ? SatMin : SatMax;
    end else begin
      sat_add = s[SAMPLE_BITS-1:0];
    end
  endfunction

  // unpacked so that each total compares as a signed value
  logic signed [SAMPLE_BITS-1:0]                  total [NumBranches];
  logic [NumBranches-1:0][MsgBits-1:0]            code;
  logic signed [SAMPLE_BITS-1:0]                  m01, m23;
  logic [MsgBits-1:0]                             c01, c23;

  // Branch totals and full message labels
  always_comb begin
    for (int i = 0; i < NumBranches; i++) begin
      total[i] = sat_add(left_metric_i[i], right_metric_i[i]);
      code[i]  = {code_i.right[i], code_i.left[i]};
    end
  end

  // Two-level minimum tree, ties to the second candidate
  always_comb begin
    if (total[0] < total[1]) begin
      m01 = total[0]; c01 = code[0];
    end else begin
      m01 = total[1]; c01 = code[1];
    end
    if (total[2] < total[3]) begin
      m23 = total[2]; c23 = code[2];
    end else begin
      m23 = total[3]; c23 = code[3];
    end
    message_o = (m01 < m23) ? c01 : c23;
  end

endmodule
